// ===== rtl/core/usm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers of the unsharp mask block.
// No dependencies; every other file imports this package.
package usm_pkg;

    // Width of the configuration write data (widest register).
    localparam int CFG_DW = 16;

    // Configuration register indexes.
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // Horizontal window taps, named by their offset from the center pixel.
    localparam logic [2:0] WIN_P2 = 3'd0;  // pixel arriving with this item
    localparam logic [2:0] WIN_P1 = 3'd1;
    localparam logic [2:0] WIN_C  = 3'd2;
    localparam logic [2:0] WIN_M1 = 3'd3;
    localparam logic [2:0] WIN_M2 = 3'd4;

    // Vertical tap source: codes below this pick a line store slot.
    localparam logic [2:0] SEL_FRESH = 3'd4;

    // Reciprocal of five for values below 2048.
    localparam logic [13:0] RECIP5       = 14'd13108;
    localparam int          RECIP5_SHIFT = 16;

    // Per-item steering that the controller hands to every lane.
    typedef struct packed {
        logic            shift;  // advance the horizontal window
        logic            wr;     // write the horizontal blur to a line store
        logic [1:0]      wslot;  // line store slot that is written
        logic [4:0][2:0] hsel;   // window position for each horizontal tap
        logic [4:0][2:0] vsel;   // slot or fresh value for each vertical tap
    } lane_ctl_t;

    // Per-item result description for the pipeline in the top level.
    typedef struct packed {
        logic result;  // this item produces an output item
        logic pt;      // pass-through output
        logic fe;      // last output of the frame
    } item_ctl_t;

    // 1-4-6-4-1 weighted sum, divided by 16 with truncation.
    function automatic logic [7:0] blur5(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                         logic [7:0] d, logic [7:0] e);
        logic [11:0] sum;
        sum = {4'b0, a} + {4'b0, e} + {2'b0, b, 2'b0} + {2'b0, d, 2'b0}
            + {2'b0, c, 2'b0} + {3'b0, c, 1'b0};
        return sum[11:4];
    endfunction

    // round((7*s - 2*b) / 5), clamped to a byte.
    function automatic logic [7:0] sharpen(logic [7:0] s, logic [7:0] b);
        logic signed [12:0] v;
        logic [10:0]        n;
        logic [24:0]        prod;
        logic [8:0]         q;
        v = $signed({2'b00, s, 3'b000}) - $signed({5'b0, s}) - $signed({4'b0, b, 1'b0});
        n = v[10:0] + 11'd2;
        prod = {14'b0, n} * {11'b0, RECIP5};
        q = prod[24:RECIP5_SHIFT];
        if (v <= 13'sd0) begin
            return 8'd0;
        end else if (q > 9'd255) begin
            return 8'hFF;
        end else begin
            return q[7:0];
        end
    endfunction

endpackage

// ===== rtl/core/usm_ctrl.sv =====
`timescale 1ns / 1ps
// Frame position counters, configuration registers and per-item steering.
// Depends on usm_pkg.
module usm_ctrl import usm_pkg::*; #(
    parameter  int MAX_WIDTH = 2048,
    localparam int AW        = $clog2(MAX_WIDTH),
    localparam int SDEPTH    = 2 * MAX_WIDTH + 4,
    localparam int SAW       = $clog2(SDEPTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              acc,
    input  logic              func,
    input  logic              cfg_wr_en,
    input  logic              cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wr_data,
    output lane_ctl_t         lane_ctl,
    output logic [AW-1:0]     col_addr,
    output item_ctl_t         item,
    output logic              src_we,
    output logic [SAW-1:0]    src_waddr,
    output logic [SAW-1:0]    src_raddr
);

    localparam logic [13:0]    MAX_W     = 14'(MAX_WIDTH);
    localparam logic [SAW-1:0] SRC_LAST  = SAW'(SDEPTH - 1);

    logic [11:0]    width_reg;
    logic [15:0]    height_reg;
    logic [11:0]    col_reg;
    logic [15:0]    row_reg;
    logic [11:0]    pcol_reg;
    logic [16:0]    prow_reg;
    logic           pending_reg;
    logic [SAW-1:0] wp_reg;
    logic [SAW-1:0] rp_reg;

    logic filt, pixel, nz_total, at_origin, past2, col_last, row_last;
    logic pcol_first, pcol_second, pcol_last, pcol_prev;
    logic prow_ge2, has, r0, r1, rl, rm;
    logic femit, hb_pix, pemit, hb_wr, fe_f, fe_pt, pt_res;
    logic [16:0]    h_plus1;
    logic [1:0]     base;
    logic [SAW-1:0] waddr;
    logic [SAW-1:0] rp_inc;

    assign filt = (width_reg >= 12'd3) && ({2'b00, width_reg} <= MAX_W)
                  && (height_reg >= 16'd3);
    assign pixel     = !func;
    assign nz_total  = (width_reg != 12'd0) && (height_reg != 16'd0);
    assign at_origin = (col_reg == 12'd0) && (row_reg == 16'd0);
    assign past2     = (row_reg != 16'd0) || (col_reg >= 12'd2);
    assign col_last  = col_reg == width_reg - 12'd1;
    assign row_last  = row_reg == height_reg - 16'd1;

    assign pcol_first  = pcol_reg == 12'd0;
    assign pcol_second = pcol_reg == 12'd1;
    assign pcol_last   = pcol_reg == width_reg - 12'd1;
    assign pcol_prev   = pcol_reg == width_reg - 12'd2;

    // The blur position counter runs two rows ahead of the output row.
    assign h_plus1  = {1'b0, height_reg} + 17'd1;
    assign prow_ge2 = prow_reg >= 17'd2;
    assign has      = prow_reg < {1'b0, height_reg};
    assign r0       = prow_reg == 17'd2;
    assign r1       = prow_reg == 17'd3;
    assign rl       = prow_reg == h_plus1;
    assign rm       = prow_reg == {1'b0, height_reg};

    assign femit  = filt && func && at_origin && pending_reg;
    assign hb_pix = filt && pixel && past2;
    assign pemit  = hb_pix && prow_ge2;
    assign hb_wr  = hb_pix || (femit && has);
    assign fe_f   = rl && pcol_last;
    assign pt_res = !filt && pixel;
    assign fe_pt  = nz_total && col_last && row_last;

    assign base = prow_reg[1:0] - 2'd2;

    always_comb begin
        lane_ctl.shift   = acc && ((filt && pixel) || femit);
        lane_ctl.wr      = acc && hb_wr;
        lane_ctl.wslot   = prow_reg[1:0];
        lane_ctl.hsel[0] = pcol_first ? WIN_P2 : (pcol_second ? WIN_C : WIN_M2);
        lane_ctl.hsel[1] = pcol_first ? WIN_P1 : WIN_M1;
        lane_ctl.hsel[2] = WIN_C;
        lane_ctl.hsel[3] = pcol_last ? WIN_M1 : WIN_P1;
        lane_ctl.hsel[4] = pcol_last ? WIN_M2 : (pcol_prev ? WIN_C : WIN_P2);
        lane_ctl.vsel[0] = r0 ? SEL_FRESH : (r1 ? {1'b0, base} : {1'b0, base + 2'd2});
        lane_ctl.vsel[1] = r0 ? {1'b0, base + 2'd1} : {1'b0, base + 2'd3};
        lane_ctl.vsel[2] = {1'b0, base};
        lane_ctl.vsel[3] = rl ? {1'b0, base + 2'd3} : {1'b0, base + 2'd1};
        lane_ctl.vsel[4] = rl ? {1'b0, base + 2'd2} : (rm ? {1'b0, base} : SEL_FRESH);
    end

    assign col_addr = AW'(pcol_reg);

    assign item.result = pemit || femit || pt_res;
    assign item.pt     = pt_res;
    assign item.fe     = pt_res ? fe_pt : (femit && fe_f);

    assign waddr     = at_origin ? '0 : wp_reg;
    assign src_we    = acc && filt && pixel;
    assign src_waddr = waddr;
    assign src_raddr = rp_reg;
    assign rp_inc    = (rp_reg == SRC_LAST) ? '0 : rp_reg + SAW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= '0;
            height_reg  <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            pcol_reg    <= '0;
            prow_reg    <= '0;
            pending_reg <= 1'b0;
            wp_reg      <= '0;
            rp_reg      <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_addr == CFG_FRAME_WIDTH) begin
                width_reg <= cfg_wr_data[11:0];
            end else begin
                height_reg <= cfg_wr_data;
            end
            col_reg     <= '0;
            row_reg     <= '0;
            pending_reg <= 1'b0;
        end else if (acc) begin
            if ((pixel && !filt && nz_total) || (pixel && filt)) begin
                if (col_last) begin
                    col_reg <= '0;
                    row_reg <= row_last ? '0 : row_reg + 16'd1;
                end else begin
                    col_reg <= col_reg + 12'd1;
                end
            end
            if (filt && pixel) begin
                wp_reg <= (waddr == SRC_LAST) ? '0 : waddr + SAW'(1);
                if (at_origin) begin
                    pending_reg <= 1'b0;
                    rp_reg      <= '0;
                    pcol_reg    <= '0;
                    prow_reg    <= '0;
                end
                if (pemit) begin
                    pending_reg <= 1'b1;
                    rp_reg      <= rp_inc;
                end
            end
            if (femit) begin
                rp_reg <= rp_inc;
                if (fe_f) begin
                    pending_reg <= 1'b0;
                end
            end
            if (hb_pix || femit) begin
                if (pcol_last) begin
                    pcol_reg <= '0;
                    prow_reg <= prow_reg + 17'd1;
                end else begin
                    pcol_reg <= pcol_reg + 12'd1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/usm_lane.sv =====
`timescale 1ns / 1ps
// One color lane: horizontal window, four line stores, vertical blur, sharpen.
// Depends on usm_pkg.
module usm_lane import usm_pkg::*; #(
    parameter  int MAX_WIDTH = 2048,
    localparam int AW        = $clog2(MAX_WIDTH)
) (
    input  logic          aclk,
    input  logic          en1,
    input  logic          en2,
    input  lane_ctl_t     ctl,
    input  logic [AW-1:0] col_addr,
    input  logic [7:0]    pix_in,
    input  logic [7:0]    src2,
    output logic [7:0]    sharp
);

    logic [7:0] x_reg [1:4];
    logic [7:0] win [5];
    logic [7:0] fresh;
    logic [7:0] slot_q [4];
    logic [7:0] fresh_reg;
    logic [4:0][2:0] vsel_reg;
    logic [7:0] vopt [5];
    logic [7:0] blur_reg;

    assign win[0] = pix_in;
    assign win[1] = x_reg[1];
    assign win[2] = x_reg[2];
    assign win[3] = x_reg[3];
    assign win[4] = x_reg[4];

    assign fresh = blur5(win[ctl.hsel[0]], win[ctl.hsel[1]], win[ctl.hsel[2]],
                         win[ctl.hsel[3]], win[ctl.hsel[4]]);

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            x_reg[1] <= pix_in;
            x_reg[2] <= x_reg[1];
            x_reg[3] <= x_reg[2];
            x_reg[4] <= x_reg[3];
        end
    end

    // Four row slots; each is read at the column of the item and written there.
    for (genvar g = 0; g < 4; g++) begin : g_slot
        logic [7:0] mem [MAX_WIDTH];
        logic [7:0] rd_reg;
        always_ff @(posedge aclk) begin
            if (ctl.wr && (ctl.wslot == 2'(g))) begin
                mem[col_addr] <= fresh;
            end
            if (en1) begin
                rd_reg <= mem[col_addr];
            end
        end
        assign slot_q[g] = rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            fresh_reg <= fresh;
            vsel_reg  <= ctl.vsel;
        end
    end

    assign vopt[0] = slot_q[0];
    assign vopt[1] = slot_q[1];
    assign vopt[2] = slot_q[2];
    assign vopt[3] = slot_q[3];
    assign vopt[4] = fresh_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            blur_reg <= blur5(vopt[vsel_reg[0]], vopt[vsel_reg[1]], vopt[vsel_reg[2]],
                              vopt[vsel_reg[3]], vopt[vsel_reg[4]]);
        end
    end

    assign sharp = sharpen(src2, blur_reg);

endmodule

// ===== rtl/core/usm_merge.sv =====
`timescale 1ns / 1ps
// Output register that merges the three lanes with alpha and frame end.
// Depends on usm_pkg.
module usm_merge import usm_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            v2,
    input  logic            pt2,
    input  logic            fe2,
    input  logic [31:0]     src2,
    input  logic [2:0][7:0] sharp,
    input  logic            m_ready,
    output logic            en3,
    output logic            m_valid,
    output logic [7:0]      m_red_out,
    output logic [7:0]      m_green_out,
    output logic [7:0]      m_blue_out,
    output logic [7:0]      m_alpha_out,
    output logic            m_frame_end
);

    logic       valid_reg;
    logic [7:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic       fe_reg;

    assign en3 = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en3) begin
            valid_reg <= v2;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            red_reg   <= pt2 ? src2[7:0]   : sharp[0];
            green_reg <= pt2 ? src2[15:8]  : sharp[1];
            blue_reg  <= pt2 ? src2[23:16] : sharp[2];
            alpha_reg <= src2[31:24];
            fe_reg    <= fe2;
        end
    end

    assign m_valid     = valid_reg;
    assign m_red_out   = red_reg;
    assign m_green_out = green_reg;
    assign m_blue_out  = blue_reg;
    assign m_alpha_out = alpha_reg;
    assign m_frame_end = fe_reg;

endmodule

// ===== rtl/core/unsharp_mask_binomial_5tap_top.sv =====
`timescale 1ns / 1ps
// Top level of the streaming RGBA unsharp mask with a 5-tap binomial blur.
// Depends on usm_pkg, usm_ctrl, usm_lane and usm_merge.
//
//  Channel   Handshake           Payload
//  input     s_valid / s_ready   s_func, s_red_in, s_green_in, s_blue_in, s_alpha_in
//  result    m_valid / m_ready   m_red_out, m_green_out, m_blue_out, m_alpha_out,
//                                m_frame_end
//  config    cfg_wr_en           cfg_addr, cfg_wr_data (write only, no wait)
//
// The block takes one item per clock unless a stalled output holds s_ready low.
// A result item passes through stage one, stage two and the output register; the
// three stages are set by the registered reads of line stores and source delay memory.
// Reset is synchronous on aresetn and clears only control state; the line stores
// need no clearing pass, since every entry is written before it is read.
// A stalled output fills the pipeline stage by stage, and s_ready drops only once
// all three stages hold results.
module unsharp_mask_binomial_5tap_top import usm_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_func,
    input  logic [7:0]        s_red_in,
    input  logic [7:0]        s_green_in,
    input  logic [7:0]        s_blue_in,
    input  logic [7:0]        s_alpha_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_red_out,
    output logic [7:0]        m_green_out,
    output logic [7:0]        m_blue_out,
    output logic [7:0]        m_alpha_out,
    output logic              m_frame_end,
    input  logic              cfg_wr_en,
    input  logic              cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wr_data
);

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int SDEPTH = 2 * MAX_WIDTH + 4;
    localparam int SAW    = $clog2(SDEPTH);

    // Handshake and stage enables. Each stage moves when the next one has room.
    logic acc, en1, en2, en3;

    lane_ctl_t      lane_ctl;
    item_ctl_t      item;
    logic [AW-1:0]  col_addr;
    logic           src_we;
    logic [SAW-1:0] src_waddr, src_raddr;
    logic [31:0]    pix;

    // The source delay line keeps every pixel of a filtered frame until its output is formed.
    logic [31:0] src_mem [SDEPTH];
    logic [31:0] src_q_reg;

    // Stage one follows the acceptance edge, stage two holds the vertical blur.
    logic        v1_reg, pt1_reg, fe1_reg;
    logic [31:0] pix1_reg;
    logic        v2_reg, pt2_reg, fe2_reg;
    logic [31:0] src2_reg;

    logic [2:0][7:0] sharp;

    assign pix = {s_alpha_in, s_blue_in, s_green_in, s_red_in};

    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign acc     = s_valid && s_ready;

    usm_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .acc         (acc),
        .func        (s_func),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .lane_ctl    (lane_ctl),
        .col_addr    (col_addr),
        .item        (item),
        .src_we      (src_we),
        .src_waddr   (src_waddr),
        .src_raddr   (src_raddr)
    );

    always_ff @(posedge aclk) begin
        if (src_we) begin
            src_mem[src_waddr] <= pix;
        end
        if (en1) begin
            src_q_reg <= src_mem[src_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= acc && item.result;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            pt1_reg  <= item.pt;
            fe1_reg  <= item.fe;
            pix1_reg <= pix;
        end
        if (en2) begin
            pt2_reg  <= pt1_reg;
            fe2_reg  <= fe1_reg;
            // A pass-through item carries its own pixel; a filtered one reads it back.
            src2_reg <= pt1_reg ? pix1_reg : src_q_reg;
        end
    end

    // One lane per color channel, all steered by the same controller outputs.
    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        usm_lane #(.MAX_WIDTH(MAX_WIDTH)) u_lane (
            .aclk     (aclk),
            .en1      (en1),
            .en2      (en2),
            .ctl      (lane_ctl),
            .col_addr (col_addr),
            .pix_in   (pix[8*ch +: 8]),
            .src2     (src2_reg[8*ch +: 8]),
            .sharp    (sharp[ch])
        );
    end

    usm_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .v2          (v2_reg),
        .pt2         (pt2_reg),
        .fe2         (fe2_reg),
        .src2        (src2_reg),
        .sharp       (sharp),
        .m_ready     (m_ready),
        .en3         (en3),
        .m_valid     (m_valid),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_alpha_out (m_alpha_out),
        .m_frame_end (m_frame_end)
    );

    // With the output register empty the block must be able to take an item.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty output register");

    // An accepted item that produces a result enters stage one.
    a_result_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && item.result |=> v1_reg)
        else $error("result item lost at stage one");

    // A blocked stage one keeps its item.
    a_stage1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && !en2 |=> v1_reg)
        else $error("stage one item dropped under stall");

    // Pass-through items never touch the line stores.
    a_pt_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && item.pt |-> !lane_ctl.wr && !src_we)
        else $error("pass-through item wrote a store");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for unsharp_mask_binomial_5tap_top: a scoreboard class that
// predicts every sharpened or passed-through pixel, and tasks that drive both channels.
// Depends on usm_pkg and the RTL of the block; reads no files.

typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       fe;
} usm_pix_t;

// Tracks the frame position and both line stores, so that each accepted item can be
// turned into the pixel that the block should return for it, if any.
class usm_scoreboard;
    localparam int unsigned LINE_MAX = 2048;
    localparam int unsigned SRC_N    = 2 * LINE_MAX + 4;

    logic [31:0]  src_line [SRC_N];
    logic [23:0]  hblur_rows [4 * LINE_MAX];
    int unsigned  col, row, out_idx, w, h;
    usm_pix_t     expected_px [$];
    int unsigned  mismatches, matched, pixels_in, flushes_in;

    function new();
        col = 0; row = 0; out_idx = 0; w = 0; h = 0;
        mismatches = 0; matched = 0; pixels_in = 0; flushes_in = 0;
    endfunction

    // Any register write abandons the frame in progress.
    function void set_frame(int unsigned fw, int unsigned fh);
        w = fw & 12'hFFF;
        h = fh & 16'hFFFF;
        col = 0; row = 0; out_idx = 0;
    endfunction

    function int fold(int i, int n);
        if (i < 0) return -i;
        if (i >= n) return 2 * n - i - 2;
        return i;
    endfunction

    function int unsigned tap(int t);
        return (t == 2) ? 6 : ((t == 1 || t == 3) ? 4 : 1);
    endfunction

    function logic [7:0] boost(int unsigned s, int unsigned bl);
        int v;
        int unsigned q;
        v = 7 * int'(s) - 2 * int'(bl);
        if (v <= 0) return 8'd0;
        q = (v + 2) / 5;
        return (q > 255) ? 8'hFF : q[7:0];
    endfunction

    // Horizontal blur of raster position p, packed R, G<<8, B<<16.
    function logic [23:0] row_blur(int unsigned p);
        int unsigned c0, base, px;
        int unsigned acc [3];
        int c;
        c0 = p % w;
        base = p - c0;
        acc = '{0, 0, 0};
        for (int t = 0; t < 5; t++) begin
            c = fold(int'(c0) + t - 2, int'(w));
            px = src_line[(base + c) % SRC_N];
            for (int ch = 0; ch < 3; ch++) acc[ch] += ((px >> (8 * ch)) & 255) * tap(t);
        end
        return {8'(acc[2] >> 4), 8'(acc[1] >> 4), 8'(acc[0] >> 4)};
    endfunction

    function void keep_blur(int unsigned p, logic [23:0] v);
        hblur_rows[((p / w) % 4) * LINE_MAX + p % w] = v;
    endfunction

    // Output pixel k; fresh is the horizontal blur of the row two below it.
    function usm_pix_t make_out(int unsigned k, logic [23:0] fresh, bit has_fresh);
        usm_pix_t    o;
        int unsigned ox, px;
        int unsigned acc [3];
        int          oy, r;
        logic [23:0] hv;
        ox = k % w;
        oy = int'(k / w);
        px = src_line[k % SRC_N];
        acc = '{0, 0, 0};
        for (int t = 0; t < 5; t++) begin
            r = fold(oy + t - 2, int'(h));
            if (has_fresh && r == oy + 2) hv = fresh;
            else hv = hblur_rows[(r % 4) * LINE_MAX + ox];
            for (int ch = 0; ch < 3; ch++) acc[ch] += ((hv >> (8 * ch)) & 255) * tap(t);
        end
        o.r = boost(px & 255, acc[0] >> 4);
        o.g = boost((px >> 8) & 255, acc[1] >> 4);
        o.b = boost((px >> 16) & 255, acc[2] >> 4);
        o.a = px[31:24];
        o.fe = (k == w * h - 1);
        return o;
    endfunction

    function void step_pos();
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
    endfunction

    // Called once per accepted input item.
    function void note_item(bit flush, logic [31:0] pix);
        int unsigned total, n, k, p;
        logic [23:0] fresh;
        bit          has;
        usm_pix_t    o;
        total = w * h;
        if (flush) flushes_in++;
        else pixels_in++;
        if (!(w >= 3 && w <= LINE_MAX && h >= 3)) begin
            if (flush) return;
            {o.a, o.b, o.g, o.r} = pix;
            if (total == 0) begin
                o.fe = 0;
            end else begin
                n = row * w + col;
                if (n >= total) begin
                    row = 0; col = 0; n = 0;
                end
                o.fe = (n == total - 1);
                step_pos();
            end
            expected_px.push_back(o);
            return;
        end
        if (flush) begin
            if (row != 0 || col != 0) return;
            if (out_idx == 0 || out_idx >= total) return;
            k = out_idx;
            p = k + 2 * w;
            has = p < total;
            fresh = has ? row_blur(p) : 24'd0;
            expected_px.push_back(make_out(k, fresh, has));
            if (has) keep_blur(p, fresh);
            out_idx = (k + 1 == total) ? 0 : k + 1;
            return;
        end
        n = row * w + col;
        if (n >= total) begin
            row = 0; col = 0; n = 0;
        end
        if (n == 0) out_idx = 0;
        src_line[n % SRC_N] = pix;
        if (n >= 2) begin
            p = n - 2;
            fresh = row_blur(p);
            if (p >= 2 * w) begin
                k = p - 2 * w;
                expected_px.push_back(make_out(k, fresh, 1'b1));
                out_idx = k + 1;
            end
            keep_blur(p, fresh);
        end
        step_pos();
    endfunction

    // Called once per accepted result item.
    function void check_pixel(usm_pix_t got);
        usm_pix_t want;
        if (expected_px.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result r=%0d g=%0d b=%0d a=%0d fe=%0d",
                         got.r, got.g, got.b, got.a, got.fe);
            return;
        end
        want = expected_px.pop_front();
        if (got.r !== want.r || got.g !== want.g || got.b !== want.b || got.a !== want.a
            || got.fe !== want.fe) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: rgba/fe expected %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                         want.r, want.g, want.b, want.a, want.fe,
                         got.r, got.g, got.b, got.a, got.fe);
        end else begin
            matched++;
        end
    endfunction
endclass

module tb_top;
    import usm_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 10;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_func = 1'b0;
    logic [7:0]        s_red_in = '0, s_green_in = '0, s_blue_in = '0, s_alpha_in = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [7:0]        m_red_out, m_green_out, m_blue_out, m_alpha_out;
    logic              m_frame_end;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_addr = CFG_FRAME_WIDTH;
    logic [CFG_DW-1:0] cfg_wr_data = '0;

    usm_scoreboard sb = new();

    // Idle rates in percent for both sides, and a pending long stall of the receiver.
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          recv_hold = 0;
    int          quiet_cycles = 0;
    int unsigned random_pixels = 0;
    int unsigned frames_run = 0;

    unsharp_mask_binomial_5tap_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_red_in(s_red_in), .s_green_in(s_green_in), .s_blue_in(s_blue_in),
        .s_alpha_in(s_alpha_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red_out(m_red_out), .m_green_out(m_green_out), .m_blue_out(m_blue_out),
        .m_alpha_out(m_alpha_out), .m_frame_end(m_frame_end),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: a long stall, when requested, is counted down here; otherwise ready
    // is dropped at the current idle rate.
    always @(posedge aclk) begin
        if (recv_hold > 0) begin
            recv_hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every accepted result item goes to the scoreboard.
    always @(posedge aclk) begin
        usm_pix_t got;
        if (aresetn && m_valid && m_ready) begin
            got.r = m_red_out;
            got.g = m_green_out;
            got.b = m_blue_out;
            got.a = m_alpha_out;
            got.fe = m_frame_end;
            sb.check_pixel(got);
        end
    end

    // The watchdog ends a run in which neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one item and returns on the edge at which it is accepted. Valid is only
    // lowered when an idle gap is inserted, and then on a different edge than it rises.
    task automatic put_item(bit flush, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [7:0] a);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= flush;
        s_red_in <= r;
        s_green_in <= g;
        s_blue_in <= b;
        s_alpha_in <= a;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(flush, {a, b, g, r});
    endtask

    // Channel values lean toward the extremes so that clamping is hit often.
    function automatic logic [7:0] chan_val();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) return 8'h00;
        if (sel < 30) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic put_pixel();
        put_item(1'b0, chan_val(), chan_val(), chan_val(), 8'($urandom_range(255)));
    endtask

    task automatic put_flush();
        put_item(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    // The sender holds still until every predicted item has come back, then waits
    // out the pipeline so that the block is truly idle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.expected_px.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Both registers are written, width first and then height; only ever while idle.
    task automatic write_frame(int unsigned fw, int unsigned fh);
        cfg_wr_en <= 1'b1;
        cfg_addr <= CFG_FRAME_WIDTH;
        cfg_wr_data <= CFG_DW'(fw);
        @(posedge aclk);
        cfg_addr <= CFG_FRAME_HEIGHT;
        cfg_wr_data <= CFG_DW'(fh);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_frame(fw, fh);
    endtask

    // One frame of random pixels with some stray flushes mixed in. The drain is
    // full, partial (the next frame then cuts in), or followed by spare flushes.
    task automatic run_frame(int unsigned fw, int unsigned fh, int drain_mode);
        int unsigned total;
        total = fw * fh;
        for (int unsigned n = 0; n < total; n++) begin
            if ($urandom_range(99) < 4) put_flush();
            put_pixel();
            random_pixels++;
        end
        if (drain_mode == 1) begin
            repeat ($urandom_range(0, 2 * fw + 1)) put_flush();
        end else if (fw >= 3 && fh >= 3) begin
            repeat (2 * fw + 2 + (drain_mode == 2 ? $urandom_range(1, 3) : 0)) put_flush();
        end
        frames_run++;
    endtask

    initial begin
        int unsigned fw, fh;
        int          sel;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty frame straight out of reset, extremes and a flush that does
        // nothing.
        put_item(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        put_item(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        put_item(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        wait_drained();

        // Directed: smallest filtered frame as a checkerboard of magenta and green,
        // with a flush before the frame is complete, one before any pixel and one
        // after the frame has fully drained.
        write_frame(3, 3);
        put_item(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        for (int i = 0; i < 9; i++) begin
            if (i == 4) put_item(1'b1, 8'hAA, 8'h55, 8'hAA, 8'h55);
            if (i % 2 == 0) put_item(1'b0, 8'hFF, 8'h00, 8'hFF, 8'h80);
            else put_item(1'b0, 8'h00, 8'hFF, 8'h00, 8'h7F);
        end
        repeat (9) put_item(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        wait_drained();

        // Register extremes: widest pass-through width, tallest height, both filtered
        // and not.
        write_frame(4095, 3);
        repeat (6) put_pixel();
        wait_drained();
        write_frame(3, 65535);
        repeat (12) put_pixel();
        wait_drained();
        write_frame(2, 65535);
        repeat (5) put_pixel();
        wait_drained();

        // Random frames; receiver-heavy idling first, then sender-heavy, then none.
        send_idle_pct = 12;
        recv_idle_pct = 64;
        while (random_pixels < 280) begin
            if (random_pixels >= 190) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (random_pixels >= 95) begin
                send_idle_pct = 64;
                recv_idle_pct = 12;
            end
            sel = $urandom_range(99);
            if (sel < 15) begin
                fw = $urandom_range(0, 4);
                fh = (fw < 3) ? $urandom_range(0, 5) : $urandom_range(0, 2);
            end else begin
                fw = $urandom_range(3, 10);
                fh = $urandom_range(3, 6);
            end
            // Most frames get a fresh setting; some reuse the previous one, so that
            // a frame can cut into the drain of the one before.
            if (frames_run == 0 || $urandom_range(99) < 70) begin
                wait_drained();
                write_frame(fw, fh);
            end else begin
                fw = sb.w;
                fh = sb.h;
            end
            run_frame(fw, fh, $urandom_range(2));
        end

        // A wider frame with a long receiver stall at the start so that the
        // pipeline fills and the input backs up.
        wait_drained();
        write_frame(16, 3);
        recv_hold = 300;
        run_frame(16, 3, 0);
        wait_drained();

        $display("Covered %0d frames, %0d pixel and %0d flush items, %0d results checked.",
                 frames_run + 5, sb.pixels_in, sb.flushes_in, sb.matched);
        if (sb.mismatches == 0 && sb.expected_px.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.expected_px.size());
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/usm_pkg.sv
rtl/core/usm_ctrl.sv
rtl/core/usm_lane.sv
rtl/core/usm_merge.sv
rtl/core/unsharp_mask_binomial_5tap_top.sv
tb/tb_top.sv
